// ===== sv/khcp_pkg.sv =====
// Shared types, codes and command tables of the keyer host command parser.
package khcp_pkg;

	localparam int FIFO_DEPTH_DEF  = 512;
	localparam int XOFF_MARGIN_DEF = 32;

	localparam logic [7:0] SPEED_RESET = 8'd20;

	// escape marks stored in the send buffer
	localparam logic [7:0] ESC_SPD = 8'hFE;
	localparam logic [7:0] ESC_MRG = 8'hFD;

	localparam logic [7:0] TEXT_MIN  = 8'h20;
	localparam logic [7:0] OP_ADMIN  = 8'h00;

	// immediate commands
	localparam logic [7:0] OP_SPEED     = 8'h02;
	localparam logic [7:0] OP_PAUSE     = 8'h06;
	localparam logic [7:0] OP_BKSP      = 8'h08;
	localparam logic [7:0] OP_CLEAR     = 8'h0A;
	localparam logic [7:0] OP_SPEED_EXT = 8'h0F;
	localparam logic [7:0] OP_PROSIGN   = 8'h1B;
	localparam logic [7:0] OP_BUF_SPEED = 8'h1C;
	localparam logic [7:0] OP_CAN_SPEED = 8'h1E;

	// admin subcommands
	localparam logic [7:0] ADM_RESET = 8'h01;
	localparam logic [7:0] ADM_OPEN  = 8'h02;
	localparam logic [7:0] ADM_CLOSE = 8'h03;

	// result kinds
	localparam logic [2:0] KIND_FRAME = 3'd0;
	localparam logic [2:0] KIND_TEXT  = 3'd1;
	localparam logic [2:0] KIND_SPEED = 3'd2;
	localparam logic [2:0] KIND_MERGE = 3'd3;
	localparam logic [2:0] KIND_NONE  = 3'd4;

	typedef struct packed {
		logic [2:0] kind;
		logic       is_admin;
		logic [7:0] opcode;
		logic [3:0] param_count;
		logic [3:0] param_index;
		logic [7:0] value;
		logic       last;
	} res_t;

	typedef struct packed {
		res_t       res;
		logic       host_open;
		logic       paused;
		logic [8:0] buffered_count;
		logic       xoff;
	} out_t;

	function automatic logic [3:0] imm_count(input logic [4:0] op);
		logic [3:0] n;
		case (op)
			5'h00, 5'h07, 5'h08, 5'h0A, 5'h13, 5'h15, 5'h1E, 5'h1F: n = 4'd0;
			5'h04, 5'h1B: n = 4'd2;
			5'h05:        n = 4'd3;
			5'h0F:        n = 4'd15;
			default:      n = 4'd1;
		endcase
		return n;
	endfunction

	function automatic logic [3:0] admin_count(input logic [7:0] sub);
		logic [3:0] n;
		case (sub)
			8'h04, 8'h0E, 8'h0F, 8'h14: n = 4'd1;
			8'h0D:                      n = 4'd15;
			default:                    n = 4'd0;
		endcase
		return n;
	endfunction

endpackage

// ===== sv/khcp_in_if.sv =====
// Input channel: host bytes and pull requests.
interface khcp_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] data_byte;

	modport source (output valid, output cmd, output data_byte, input ready);
	modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

// ===== sv/khcp_out_if.sv =====
// Output channel: frame elements, send elements and status.
interface khcp_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic       is_admin;
	logic [7:0] opcode;
	logic [3:0] param_count;
	logic [3:0] param_index;
	logic [7:0] value;
	logic       last;
	logic       host_open;
	logic       paused;
	logic [8:0] buffered_count;
	logic       xoff;

	modport source (output valid, output kind, output is_admin, output opcode,
		output param_count, output param_index, output value, output last,
		output host_open, output paused, output buffered_count, output xoff,
		input ready);
	modport sink (input valid, input kind, input is_admin, input opcode,
		input param_count, input param_index, input value, input last,
		input host_open, input paused, input buffered_count, input xoff,
		output ready);
endinterface

// ===== sv/keyer_host_command_parser_top.sv =====
// Keyer host command parser: framing, command execution and send buffer.
//
//   channel | dir | word                                   | handshake
//   req     | in  | cmd, data_byte                         | valid/ready
//   rsp     | out | kind .. last, host_open .. xoff status | valid/ready
//
// Steps: a host byte (text, command, parameter) is handled when it is taken. A pull
// is answered at once when the buffer is paused or empty; else it reads the tail
// (ST_RD1) and, for a speed escape, the byte behind it (ST_RD2): the send buffer
// RAM has one write and one read port, and its read is registered. Buffered speed
// and cancel speed push an escape and a speed byte, prosign an escape and two bytes.
// Reset: all control state clears at once; the buffer RAM is not cleared.
// Stalls: results go to a two-word output queue; req is taken while the queue
// has room and no multi-cycle item is under way.
module keyer_host_command_parser_top #(
	parameter int FIFO_DEPTH  = khcp_pkg::FIFO_DEPTH_DEF,
	parameter int XOFF_MARGIN = khcp_pkg::XOFF_MARGIN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	khcp_in_if.sink    req,
	khcp_out_if.source rsp
);

	localparam int AW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);
	localparam int XOFF_LIM = FIFO_DEPTH - XOFF_MARGIN;
	localparam logic [AW-1:0] PTR_LAST = AW'(FIFO_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PUSH = 2'd1;
	localparam logic [1:0] ST_RD1  = 2'd2;
	localparam logic [1:0] ST_RD2  = 2'd3;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? PTR_LAST : p - 1'b1;
	endfunction

	function automatic logic [CW-1:0] fill(input logic [AW-1:0] h, input logic [AW-1:0] t);
		return (h >= t) ? (CW'(h) - CW'(t)) : (CW'(h) + DEPTH_C - CW'(t));
	endfunction

	// parser and buffer control state
	logic [1:0]    state_q, state_d;
	logic [3:0]    left_q, left_d;
	logic [3:0]    seen_q, seen_d;
	logic [7:0]    pend_q, pend_d;
	logic          admin_q, admin_d;
	logic          await_q, await_d;
	logic [7:0]    fp0_q, fp0_d;
	logic [7:0]    fp1_q, fp1_d;
	logic          open_q, open_d;
	logic          pause_q, pause_d;
	logic [7:0]    speed_q, speed_d;
	logic [AW-1:0] head_q, head_d;
	logic [AW-1:0] tail_q, tail_d;
	logic [7:0]    pb0_q, pb0_d;
	logic [7:0]    pb1_q, pb1_d;
	logic [1:0]    pn_q, pn_d;
	khcp_pkg::res_t res_q, res_d;

	// send buffer RAM
	logic [7:0]    mem [FIFO_DEPTH];
	logic [7:0]    rdata_q;
	logic [AW-1:0] raddr;
	logic          we;

	// output queue
	khcp_pkg::out_t oq [2];
	logic          owr_q, ord_q;
	logic [1:0]    ocnt_q;
	khcp_pkg::out_t emit_out;
	khcp_pkg::out_t oq_head;
	logic          emit, pop;

	// combinational scratch
	logic          in_acc;
	logic [7:0]    b;
	logic          fin;
	logic [3:0]    n;
	logic          push_en;
	logic [7:0]    push_byte;
	logic          ex_en, ex_adm;
	logic [7:0]    ex_op, ex_p0, ex_p1;
	khcp_pkg::res_t emit_res;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW+8:0] cnt_ext;

	assign req.ready = (state_q == ST_IDLE) && (ocnt_q != 2'd2);
	assign in_acc    = req.valid && req.ready;
	assign b         = req.data_byte;
	assign cnt_q     = fill(head_q, tail_q);
	assign raddr     = (state_q == ST_RD1) ? ptr_inc(tail_q) : tail_q;

	always_comb begin
		state_d   = state_q;
		left_d    = left_q;
		seen_d    = seen_q;
		pend_d    = pend_q;
		admin_d   = admin_q;
		await_d   = await_q;
		fp0_d     = fp0_q;
		fp1_d     = fp1_q;
		open_d    = open_q;
		pause_d   = pause_q;
		speed_d   = speed_q;
		head_d    = head_q;
		tail_d    = tail_q;
		pb0_d     = pb0_q;
		pb1_d     = pb1_q;
		pn_d      = pn_q;
		res_d     = res_q;
		push_en   = 1'b0;
		push_byte = '0;
		emit      = 1'b0;
		emit_res  = '0;
		ex_en     = 1'b0;
		ex_adm    = 1'b0;
		ex_op     = '0;
		ex_p0     = fp0_q;
		ex_p1     = fp1_q;
		fin       = 1'b0;
		n         = '0;
		we        = 1'b0;

		emit_res.kind = khcp_pkg::KIND_NONE;

		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (req.cmd) begin
						// pull: answer at once when held or empty, else read the tail
						if (pause_q || (head_q == tail_q)) begin
							emit = 1'b1;
						end else begin
							state_d = ST_RD1;
						end
					end else if (left_q != 4'd0) begin
						// parameter byte of the pending command
						if (seen_q == 4'd0) begin
							fp0_d = b;
							ex_p0 = b;
						end
						if (seen_q == 4'd1) begin
							fp1_d = b;
							ex_p1 = b;
						end
						seen_d = seen_q + 4'd1;
						left_d = left_q - 4'd1;
						fin    = (left_q == 4'd1);
						emit   = 1'b1;
						emit_res.kind        = khcp_pkg::KIND_FRAME;
						emit_res.is_admin    = admin_q;
						emit_res.opcode      = pend_q;
						emit_res.param_count = seen_q + left_q;
						emit_res.param_index = seen_q;
						emit_res.value       = b;
						emit_res.last        = fin;
						if (fin) begin
							ex_en   = 1'b1;
							ex_adm  = admin_q;
							ex_op   = pend_q;
							admin_d = 1'b0;
						end
					end else if (await_q) begin
						n       = khcp_pkg::admin_count(b);
						await_d = 1'b0;
						pend_d  = b;
						seen_d  = '0;
						left_d  = n;
						emit    = 1'b1;
						emit_res.kind        = khcp_pkg::KIND_FRAME;
						emit_res.is_admin    = 1'b1;
						emit_res.opcode      = b;
						emit_res.param_count = n;
						emit_res.last        = (n == 4'd0);
						if (n == 4'd0) begin
							ex_en   = 1'b1;
							ex_adm  = 1'b1;
							ex_op   = b;
							admin_d = 1'b0;
						end
					end else if (b == khcp_pkg::OP_ADMIN) begin
						admin_d = 1'b1;
						await_d = 1'b1;
						emit    = 1'b1;
						emit_res.kind     = khcp_pkg::KIND_FRAME;
						emit_res.is_admin = 1'b1;
					end else if (b < khcp_pkg::TEXT_MIN) begin
						n      = khcp_pkg::imm_count(b[4:0]);
						pend_d = b;
						seen_d = '0;
						left_d = n;
						emit   = 1'b1;
						emit_res.kind        = khcp_pkg::KIND_FRAME;
						emit_res.opcode      = b;
						emit_res.param_count = n;
						emit_res.last        = (n == 4'd0);
						if (n == 4'd0) begin
							ex_en = 1'b1;
							ex_op = b;
						end
					end else if (open_q) begin
						push_en   = 1'b1;
						push_byte = b;
					end
				end
			end
			ST_PUSH: begin
				// write the remaining escape bytes, one per cycle
				push_en   = 1'b1;
				push_byte = pb0_q;
				pb0_d     = pb1_q;
				pn_d      = pn_q - 2'd1;
				if (pn_q == 2'd1) begin
					emit     = 1'b1;
					emit_res = res_q;
					state_d  = ST_IDLE;
				end
			end
			ST_RD1: begin
				state_d = ST_IDLE;
				if (rdata_q == khcp_pkg::ESC_SPD) begin
					if (cnt_q < CW'(2)) begin
						emit = 1'b1;
					end else begin
						tail_d  = ptr_inc(tail_q);
						state_d = ST_RD2;
					end
				end else begin
					tail_d = ptr_inc(tail_q);
					emit   = 1'b1;
					if (rdata_q == khcp_pkg::ESC_MRG) begin
						emit_res.kind = khcp_pkg::KIND_MERGE;
					end else begin
						emit_res.kind  = khcp_pkg::KIND_TEXT;
						emit_res.value = rdata_q;
					end
				end
			end
			ST_RD2: begin
				tail_d         = ptr_inc(tail_q);
				emit           = 1'b1;
				emit_res.kind  = khcp_pkg::KIND_SPEED;
				emit_res.value = rdata_q;
				state_d        = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// execute the command on its final byte
		if (ex_en) begin
			if (ex_adm) begin
				unique case (ex_op) inside
					khcp_pkg::ADM_RESET, khcp_pkg::ADM_CLOSE: begin
						head_d  = '0;
						tail_d  = '0;
						pause_d = 1'b0;
						open_d  = 1'b0;
					end
					khcp_pkg::ADM_OPEN: begin
						head_d  = '0;
						tail_d  = '0;
						pause_d = 1'b0;
						open_d  = 1'b1;
					end
					default: begin
					end
				endcase
			end else begin
				unique case (ex_op)
					khcp_pkg::OP_SPEED: begin
						if (ex_p0 != 8'd0) speed_d = ex_p0;
					end
					khcp_pkg::OP_PAUSE: begin
						pause_d = (ex_p0 != 8'd0);
					end
					khcp_pkg::OP_BKSP: begin
						if (head_q != tail_q) head_d = ptr_dec(head_q);
					end
					khcp_pkg::OP_CLEAR: begin
						head_d = '0;
						tail_d = '0;
					end
					khcp_pkg::OP_SPEED_EXT: begin
						speed_d = ex_p1;
					end
					khcp_pkg::OP_PROSIGN: begin
						push_en   = 1'b1;
						push_byte = khcp_pkg::ESC_MRG;
						pb0_d     = ex_p0;
						pb1_d     = ex_p1;
						pn_d      = 2'd2;
						res_d     = emit_res;
						emit      = 1'b0;
						state_d   = ST_PUSH;
					end
					khcp_pkg::OP_BUF_SPEED: begin
						push_en   = 1'b1;
						push_byte = khcp_pkg::ESC_SPD;
						pb0_d     = ex_p0;
						pn_d      = 2'd1;
						res_d     = emit_res;
						emit      = 1'b0;
						state_d   = ST_PUSH;
					end
					khcp_pkg::OP_CAN_SPEED: begin
						push_en   = 1'b1;
						push_byte = khcp_pkg::ESC_SPD;
						pb0_d     = speed_q;
						pn_d      = 2'd1;
						res_d     = emit_res;
						emit      = 1'b0;
						state_d   = ST_PUSH;
					end
					default: begin
					end
				endcase
			end
		end

		// drop a push into a full buffer
		if (push_en && (ptr_inc(head_q) != tail_q)) begin
			we     = 1'b1;
			head_d = ptr_inc(head_q);
		end
	end

	// status after the step
	assign cnt_d   = fill(head_d, tail_d);
	assign cnt_ext = {9'd0, cnt_d};

	always_comb begin
		emit_out                = '0;
		emit_out.res            = emit_res;
		emit_out.host_open      = open_d;
		emit_out.paused         = pause_d;
		emit_out.buffered_count = cnt_ext[8:0];
		emit_out.xoff           = (cnt_d > CW'(XOFF_LIM));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			left_q  <= '0;
			seen_q  <= '0;
			pend_q  <= '0;
			admin_q <= 1'b0;
			await_q <= 1'b0;
			fp0_q   <= '0;
			fp1_q   <= '0;
			open_q  <= 1'b0;
			pause_q <= 1'b0;
			speed_q <= khcp_pkg::SPEED_RESET;
			head_q  <= '0;
			tail_q  <= '0;
			pn_q    <= '0;
		end else begin
			state_q <= state_d;
			left_q  <= left_d;
			seen_q  <= seen_d;
			pend_q  <= pend_d;
			admin_q <= admin_d;
			await_q <= await_d;
			fp0_q   <= fp0_d;
			fp1_q   <= fp1_d;
			open_q  <= open_d;
			pause_q <= pause_d;
			speed_q <= speed_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			pn_q    <= pn_d;
		end
	end

	// escape bytes and held result need no reset
	always_ff @(posedge clk) begin
		pb0_q <= pb0_d;
		pb1_q <= pb1_d;
		res_q <= res_d;
	end

	// send buffer: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[head_q] <= push_byte;
		end
		rdata_q <= mem[raddr];
	end

	// two-word output queue
	assign pop     = rsp.valid && rsp.ready;
	assign oq_head = oq[ord_q];

	always_ff @(posedge clk) begin
		if (emit) begin
			oq[owr_q] <= emit_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= '0;
		end else begin
			if (emit) owr_q <= ~owr_q;
			if (pop) ord_q <= ~ord_q;
			ocnt_q <= ocnt_q + {1'b0, emit} - {1'b0, pop};
		end
	end

	assign rsp.valid          = (ocnt_q != 2'd0);
	assign rsp.kind           = oq_head.res.kind;
	assign rsp.is_admin       = oq_head.res.is_admin;
	assign rsp.opcode         = oq_head.res.opcode;
	assign rsp.param_count    = oq_head.res.param_count;
	assign rsp.param_index    = oq_head.res.param_index;
	assign rsp.value          = oq_head.res.value;
	assign rsp.last           = oq_head.res.last;
	assign rsp.host_open      = oq_head.host_open;
	assign rsp.paused         = oq_head.paused;
	assign rsp.buffered_count = oq_head.buffered_count;
	assign rsp.xoff           = oq_head.xoff;

`ifndef SYNTHESIS
	// output queue never overflows
	a_oq_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> ((ocnt_q != 2'd2) || pop))
		else $error("output queue overflow");

	a_oq_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q != 2'd3)
		else $error("output queue count out of range");

	// a pull from a live, unpaused buffer goes to the read stage
	a_pull_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && req.cmd && !pause_q && (head_q != tail_q)) |=> (state_q == ST_RD1))
		else $error("pull did not start a buffer read");

	// the buffer always keeps one slot free
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < DEPTH_C)
		else $error("send buffer fill out of range");
`endif

endmodule
